FILE: rtl/core/brte_pkg.sv
package brte_pkg;

    // Input word: raw clock registers plus bus read status
    typedef struct packed {
        logic       read_ok;
        logic [7:0] seconds_reg;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
        logic [7:0] day_reg;
        logic [7:0] weekday_reg;
        logic [7:0] month_reg;
        logic [7:0] year_reg;
    } t_in;

    // Output word
    typedef struct packed {
        logic        time_valid;
        logic [31:0] epoch_seconds;
        logic [6:0]  sec_out;
        logic [6:0]  min_out;
        logic [5:0]  hour_out;
        logic [5:0]  mday_out;
        logic [2:0]  wday_out;
        logic [4:0]  month_out;
        logic [11:0] year_out;
    } t_out;

    // Decoded fields carried down the pipeline; yd is the two-digit year
    typedef struct packed {
        logic       valid;
        logic [6:0] sec;
        logic [6:0] min;
        logic [5:0] hr;
        logic [5:0] mday;
        logic [2:0] wday;
        logic [4:0] mon;
        logic [7:0] yd;
    } t_dec;

    localparam logic [10:0] YEAR_BASE       = 11'd2000;
    localparam logic [16:0] DAYS_MAR_2000   = 17'd11017;  // 2000-03-01
    localparam logic [16:0] DAYS_MAR_1999   = 17'd10651;  // 1999-03-01
    localparam logic [16:0] DAYS_PER_YEAR   = 17'd365;
    localparam logic [17:0] SEC_PER_HOUR    = 18'd3600;
    localparam logic [17:0] SEC_PER_MIN     = 18'd60;
    localparam logic [33:0] SEC_PER_DAY     = 34'd86400;
    localparam logic [7:0]  YEARS_PER_CENT  = 8'd100;
    localparam logic [4:0]  MONTH_FEB       = 5'd2;

    // Days from March 1 to the first of month index mp (March = 0),
    // i.e. (153 * mp + 2) / 5 for mp up to 22
    function automatic logic [9:0] month_start(logic [4:0] mp);
        logic [9:0] d;
        case (mp)
            5'd0:    d = 10'd0;
            5'd1:    d = 10'd31;
            5'd2:    d = 10'd61;
            5'd3:    d = 10'd92;
            5'd4:    d = 10'd122;
            5'd5:    d = 10'd153;
            5'd6:    d = 10'd184;
            5'd7:    d = 10'd214;
            5'd8:    d = 10'd245;
            5'd9:    d = 10'd275;
            5'd10:   d = 10'd306;
            5'd11:   d = 10'd337;
            5'd12:   d = 10'd367;
            5'd13:   d = 10'd398;
            5'd14:   d = 10'd428;
            5'd15:   d = 10'd459;
            5'd16:   d = 10'd490;
            5'd17:   d = 10'd520;
            5'd18:   d = 10'd551;
            5'd19:   d = 10'd581;
            5'd20:   d = 10'd612;
            5'd21:   d = 10'd643;
            5'd22:   d = 10'd673;
            default: d = 10'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/core/brte_decode.sv
module brte_decode (
    input  brte_pkg::t_in  i_word,
    input  logic           i_clock_ready,
    output brte_pkg::t_dec o_dec
);
    import brte_pkg::*;

    function automatic logic [7:0] bcd8(logic [7:0] v);
        return 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
    endfunction

    logic       valid;
    logic [7:0] sec8;
    logic [7:0] min8;
    logic [7:0] hr8;
    logic [7:0] mday8;
    logic [7:0] mon8;
    logic [7:0] yd8;

    assign valid = i_clock_ready & i_word.read_ok & ~i_word.seconds_reg[7];
    assign sec8  = bcd8({1'b0, i_word.seconds_reg[6:0]});
    assign min8  = bcd8({1'b0, i_word.minutes_reg[6:0]});
    assign hr8   = bcd8({2'b0, i_word.hours_reg[5:0]});
    assign mday8 = bcd8({2'b0, i_word.day_reg[5:0]});
    assign mon8  = bcd8({3'b0, i_word.month_reg[4:0]});
    assign yd8   = bcd8(i_word.year_reg);

    // Zero every field of an invalid word
    always_comb begin
        o_dec = '0;
        if (valid) begin
            o_dec.valid = 1'b1;
            o_dec.sec   = sec8[6:0];
            o_dec.min   = min8[6:0];
            o_dec.hr    = hr8[5:0];
            o_dec.mday  = mday8[5:0];
            o_dec.wday  = i_word.weekday_reg[2:0];
            o_dec.mon   = mon8[4:0];
            o_dec.yd    = yd8;
        end
    end

endmodule

FILE: rtl/core/bcd_rtc_to_epoch_seconds_core.sv
// Channel | Direction | Handshake                  | Word
// in      | input     | i_in_valid / o_in_ready    | i_in_word  (brte_pkg::t_in)
// out     | output    | o_out_valid / i_out_ready  | o_out_word (brte_pkg::t_out)
// cfg     | input     | i_cfg_we, no wait          | i_cfg_data (clock_ready)
//
// Four register stages: BCD decode, year/month day counts, day total and
// time of day, then the 86400 multiply and final add into the output register.
// One word per cycle is accepted while the output is taken. Each stage loads
// when it is empty or the stage after it moves, so a stall holds every word
// in place and bubbles close up behind a stalled output.
// Synchronous active-low reset clears the stage valid bits and clock_ready.
module bcd_rtc_to_epoch_seconds_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  brte_pkg::t_in   i_in_word,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output brte_pkg::t_out  o_out_word,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data
);
    import brte_pkg::*;

    logic        r_clock_ready;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        en1, en2, en3, en4;

    t_dec        dec;
    t_dec        r_s1;
    t_dec        r_s2;
    t_dec        r_s3;
    t_out        r_out;

    logic [16:0] r_s2_base;
    logic [10:0] r_s2_dom;
    logic [16:0] r_s3_days;
    logic [17:0] r_s3_hms;

    // Stage 2 terms
    logic        le_feb;
    logic        y1999;
    logic [7:0]  yoe;
    logic [4:0]  mp;
    logic [16:0] n_base;
    logic [10:0] n_dom;

    // Stage 4 terms
    logic [33:0] day_sec;
    logic [31:0] n_epoch;
    t_out        n_out;

    assign en4 = ~r_v4 | i_out_ready;
    assign en3 = ~r_v3 | en4;
    assign en2 = ~r_v2 | en3;
    assign en1 = ~r_v1 | en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_v4;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_ready <= 1'b0;
        end else if (i_cfg_we) begin
            r_clock_ready <= i_cfg_data;
        end
    end

    brte_decode u_decode (
        .i_word        (i_in_word),
        .i_clock_ready (r_clock_ready),
        .o_dec         (dec)
    );

    // Year 2000 with a month up to February falls back to 1999
    always_comb begin
        le_feb = (r_s1.mon <= MONTH_FEB);
        y1999  = le_feb && (r_s1.yd == 8'd0);
        yoe    = r_s1.yd - 8'(le_feb);
        mp     = le_feb ? (r_s1.mon + 5'd9) : (r_s1.mon - 5'd3);
        if (y1999) begin
            n_base = DAYS_MAR_1999;
        end else begin
            n_base = DAYS_MAR_2000 + 17'(yoe) * DAYS_PER_YEAR + 17'(yoe[7:2])
                     - 17'(yoe >= YEARS_PER_CENT);
        end
        n_dom = 11'(month_start(mp)) + 11'(r_s1.mday);
    end

    always_comb begin
        day_sec = 34'(r_s3_days) * SEC_PER_DAY;
        n_epoch = day_sec[31:0] + 32'(r_s3_hms);
        n_out   = '0;
        if (r_s3.valid) begin
            n_out.time_valid    = 1'b1;
            n_out.epoch_seconds = n_epoch;
            n_out.sec_out       = r_s3.sec;
            n_out.min_out       = r_s3.min;
            n_out.hour_out      = r_s3.hr;
            n_out.mday_out      = r_s3.mday;
            n_out.wday_out      = r_s3.wday;
            n_out.month_out     = r_s3.mon;
            n_out.year_out      = 12'(YEAR_BASE) + 12'(r_s3.yd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= dec;
        end
        if (en2) begin
            r_s2      <= r_s1;
            r_s2_base <= n_base;
            r_s2_dom  <= n_dom;
        end
        if (en3) begin
            r_s3      <= r_s2;
            r_s3_days <= r_s2_base + 17'(r_s2_dom) - 17'd1;
            r_s3_hms  <= 18'(r_s2.hr) * SEC_PER_HOUR + 18'(r_s2.min) * SEC_PER_MIN
                         + 18'(r_s2.sec);
        end
        if (en4) begin
            r_out <= n_out;
        end
    end

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.time_valid |->
            o_out_word.epoch_seconds == 32'd0 && o_out_word.year_out == 12'd0)
        else $error("invalid word carries nonzero fields");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.time_valid |->
            o_out_word.year_out >= 12'd2000 && o_out_word.year_out <= 12'd2165)
        else $error("year out of range");

    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !en3 |=> r_v3 && $stable(r_s3_days) && $stable(r_s3_hms))
        else $error("stage 3 word lost during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
